@@ src/ccc_pkg.sv @@
package ccc_pkg;

    // Field formats
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived widths
    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int RW   = CW;            // square root width (len < 2^CW when colliding)
    localparam int RMW  = CW + 2;        // square root partial remainder
    localparam int D2W  = 2 * CW + 2;    // squared distance
    localparam int NW   = FB + 2;        // normal, signed Q1.FB
    localparam int PW   = FB + 1 + CW;   // normal magnitude times reach magnitude

    // Data that rides along the whole pipe
    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [CW-2:0]        r1;
        logic                 sx;
        logic                 sy;
        logic [CW:0]          ax;
        logic [CW:0]          ay;
        logic [CW-1:0]        rsum;
        logic                 coll;
        logic [CW-2:0]        depth;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
    } carry_t;

endpackage

@@ src/ccc_in_if.sv @@
interface ccc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ccc_pkg::CW-1:0]     first_x;
    logic signed [ccc_pkg::CW-1:0]     first_y;
    logic [ccc_pkg::CW-2:0]            first_radius;
    logic signed [ccc_pkg::CW-1:0]     second_x;
    logic signed [ccc_pkg::CW-1:0]     second_y;
    logic [ccc_pkg::CW-2:0]            second_radius;

    modport source (output valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, input ready);
    modport sink   (input valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, output ready);
endinterface

@@ src/ccc_out_if.sv @@
interface ccc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              colliding;
    logic signed [ccc_pkg::NW-1:0]     normal_x;
    logic signed [ccc_pkg::NW-1:0]     normal_y;
    logic signed [ccc_pkg::CW-1:0]     contact_x;
    logic signed [ccc_pkg::CW-1:0]     contact_y;
    logic [ccc_pkg::CW-2:0]            depth;

    modport source (output valid, colliding, normal_x, normal_y, contact_x, contact_y,
                    depth, input ready);
    modport sink   (input valid, colliding, normal_x, normal_y, contact_x, contact_y,
                    depth, output ready);
endinterface

@@ src/circle_circle_collision.sv @@
// Channel      Dir  Payload
// pair_in      in   first_x/y, first_radius, second_x/y, second_radius
// contact_out  out  colliding, normal_x/y, contact_x/y, depth
//
// One pair accepted per cycle while contact_out is not stalled. The pipe
// holds the one-bit-per-stage square root and the
// one-bit-per-stage normal dividers.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
// A stall on contact_out freezes the whole pipe; nothing is lost or repeated.
module circle_circle_collision
(
    input  logic         clk,
    input  logic         rst_n,
    ccc_in_if.sink       pair_in,
    ccc_out_if.source    contact_out
);

    logic adv;

    // Front end stages
    logic                         a_v_reg, b_v_reg, c_v_reg;
    ccc_pkg::carry_t              a_c_reg, b_c_reg, c_c_reg;
    logic signed [ccc_pkg::CW:0]  a_dx_reg, a_dy_reg;
    logic [ccc_pkg::D2W-1:0]      c_ax2_reg, c_ay2_reg, c_rs2_reg;

    // Next carry values for stages that update individual fields
    ccc_pkg::carry_t              a_c_next, b_c_next, sq_c_next, dv_c_next, g_c_next;

    // Square root stages, index 0 holds the squared distance
    logic                         sq_v_reg    [0:ccc_pkg::RW];
    ccc_pkg::carry_t              sq_c_reg    [0:ccc_pkg::RW];
    logic [2*ccc_pkg::CW-1:0]     sq_rad_reg  [0:ccc_pkg::RW];
    logic [ccc_pkg::RMW-1:0]      sq_rem_reg  [0:ccc_pkg::RW];
    logic [ccc_pkg::RW-1:0]       sq_root_reg [0:ccc_pkg::RW];

    // Divider stages for the normal
    logic                         dv_v_reg   [0:ccc_pkg::FB];
    ccc_pkg::carry_t              dv_c_reg   [0:ccc_pkg::FB];
    logic [ccc_pkg::RW-1:0]       dv_len_reg [0:ccc_pkg::FB];
    logic [ccc_pkg::CW:0]         dv_rx_reg  [0:ccc_pkg::FB];
    logic [ccc_pkg::CW:0]         dv_ry_reg  [0:ccc_pkg::FB];
    logic [ccc_pkg::FB:0]         dv_qx_reg  [0:ccc_pkg::FB];
    logic [ccc_pkg::FB:0]         dv_qy_reg  [0:ccc_pkg::FB];

    // Back end stages
    logic                         f_v_reg, g_v_reg, h_v_reg, i_v_reg, out_v_reg;
    ccc_pkg::carry_t              f_c_reg, g_c_reg, h_c_reg, i_c_reg;
    logic signed [ccc_pkg::CW:0]  f_reach_reg;
    logic [ccc_pkg::FB:0]         f_qx_reg, f_qy_reg, g_qx_reg, g_qy_reg;
    logic [ccc_pkg::CW-1:0]       g_rm_reg;
    logic                         g_rneg_reg, h_negx_reg, h_negy_reg;
    logic [ccc_pkg::PW-1:0]       h_px_reg, h_py_reg;
    logic signed [ccc_pkg::CW+1:0] i_ox_reg, i_oy_reg;

    logic                          out_coll_reg;
    logic signed [ccc_pkg::NW-1:0] out_nx_reg, out_ny_reg;
    logic signed [ccc_pkg::CW-1:0] out_cx_reg, out_cy_reg;
    logic [ccc_pkg::CW-2:0]        out_depth_reg;

    logic signed [ccc_pkg::CW+2:0] vx_next, vy_next;

    // Whole pipe moves when the output register is free or being drained
    assign adv           = !out_v_reg || contact_out.ready;
    assign pair_in.ready = adv;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            g_v_reg   <= 1'b0;
            h_v_reg   <= 1'b0;
            i_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k <= ccc_pkg::RW; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= ccc_pkg::FB; j++)
            begin
                dv_v_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_v_reg     <= pair_in.valid;
            b_v_reg     <= a_v_reg;
            c_v_reg     <= b_v_reg;
            sq_v_reg[0] <= c_v_reg;
            for (int k = 0; k < ccc_pkg::RW; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            dv_v_reg[0] <= sq_v_reg[ccc_pkg::RW];
            for (int j = 0; j < ccc_pkg::FB; j++)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            f_v_reg   <= dv_v_reg[ccc_pkg::FB];
            g_v_reg   <= f_v_reg;
            h_v_reg   <= g_v_reg;
            i_v_reg   <= h_v_reg;
            out_v_reg <= i_v_reg;
        end
    end

    // Stage A: centre differences, radius sum
    always_comb
    begin
        a_c_next      = '0;
        a_c_next.x1   = pair_in.first_x;
        a_c_next.y1   = pair_in.first_y;
        a_c_next.r1   = pair_in.first_radius;
        a_c_next.rsum = {1'b0, pair_in.first_radius} + {1'b0, pair_in.second_radius};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg       <= a_c_next;
            a_dx_reg      <= (ccc_pkg::CW+1)'(pair_in.first_x) -
                             (ccc_pkg::CW+1)'(pair_in.second_x);
            a_dy_reg      <= (ccc_pkg::CW+1)'(pair_in.first_y) -
                             (ccc_pkg::CW+1)'(pair_in.second_y);
        end
    end

    // Stage B: magnitudes and signs
    always_comb
    begin
        b_c_next    = a_c_reg;
        b_c_next.sx = a_dx_reg[ccc_pkg::CW];
        b_c_next.sy = a_dy_reg[ccc_pkg::CW];
        b_c_next.ax = a_dx_reg[ccc_pkg::CW] ? (ccc_pkg::CW+1)'(-a_dx_reg)
                                            : (ccc_pkg::CW+1)'(a_dx_reg);
        b_c_next.ay = a_dy_reg[ccc_pkg::CW] ? (ccc_pkg::CW+1)'(-a_dy_reg)
                                            : (ccc_pkg::CW+1)'(a_dy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_c_reg <= b_c_next;
        end
    end

    // Stage C: squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_c_reg   <= b_c_reg;
            c_ax2_reg <= ccc_pkg::D2W'(b_c_reg.ax) * ccc_pkg::D2W'(b_c_reg.ax);
            c_ay2_reg <= ccc_pkg::D2W'(b_c_reg.ay) * ccc_pkg::D2W'(b_c_reg.ay);
            c_rs2_reg <= ccc_pkg::D2W'(b_c_reg.rsum) * ccc_pkg::D2W'(b_c_reg.rsum);
        end
    end

    // Stage D: squared distance and collision test, square root seed
    logic [ccc_pkg::D2W-1:0] d2_sum;
    assign d2_sum = c_ax2_reg + c_ay2_reg;

    always_comb
    begin
        sq_c_next      = c_c_reg;
        sq_c_next.coll = (d2_sum <= c_rs2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_c_reg[0]      <= sq_c_next;
            sq_rad_reg[0]    <= d2_sum[2*ccc_pkg::CW-1:0];
            sq_rem_reg[0]    <= '0;
            sq_root_reg[0]   <= '0;
        end
    end

    // Square root: one result bit per stage
    for (genvar k = 0; k < ccc_pkg::RW; k++)
    begin : g_sqrt
        logic [ccc_pkg::RMW-1:0] cur;
        logic [ccc_pkg::RMW-1:0] trial;
        logic                    take;

        assign cur   = {sq_rem_reg[k][ccc_pkg::RMW-3:0],
                        sq_rad_reg[k][2*ccc_pkg::CW-1-2*k -: 2]};
        assign trial = {sq_root_reg[k], 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c_reg[k+1]    <= sq_c_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_reg[k];
                sq_rem_reg[k+1]  <= take ? cur - trial : cur;
                sq_root_reg[k+1] <= {sq_root_reg[k][ccc_pkg::RW-2:0], take};
            end
        end
    end

    // Divider seed: integer bit of the quotient, depth
    logic [ccc_pkg::RW-1:0] len;
    logic [ccc_pkg::CW-1:0] gap;
    logic                   gex, gey;

    assign len = sq_root_reg[ccc_pkg::RW];
    assign gap = sq_c_reg[ccc_pkg::RW].rsum - len;
    assign gex = (sq_c_reg[ccc_pkg::RW].ax >= {1'b0, len});
    assign gey = (sq_c_reg[ccc_pkg::RW].ay >= {1'b0, len});

    always_comb
    begin
        dv_c_next       = sq_c_reg[ccc_pkg::RW];
        dv_c_next.depth = gap[ccc_pkg::CW-1:1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_c_reg[0]       <= dv_c_next;
            dv_len_reg[0]     <= len;
            dv_rx_reg[0]      <= gex ? sq_c_reg[ccc_pkg::RW].ax - {1'b0, len}
                                     : sq_c_reg[ccc_pkg::RW].ax;
            dv_ry_reg[0]      <= gey ? sq_c_reg[ccc_pkg::RW].ay - {1'b0, len}
                                     : sq_c_reg[ccc_pkg::RW].ay;
            dv_qx_reg[0]      <= {{ccc_pkg::FB{1'b0}}, gex};
            dv_qy_reg[0]      <= {{ccc_pkg::FB{1'b0}}, gey};
        end
    end

    // Restoring division: one fraction bit per stage, both axes side by side
    for (genvar j = 0; j < ccc_pkg::FB; j++)
    begin : g_div
        logic [ccc_pkg::CW:0] shx, shy;
        logic                 tx, ty;

        assign shx = {dv_rx_reg[j][ccc_pkg::CW-1:0], 1'b0};
        assign shy = {dv_ry_reg[j][ccc_pkg::CW-1:0], 1'b0};
        assign tx  = (shx >= {1'b0, dv_len_reg[j]});
        assign ty  = (shy >= {1'b0, dv_len_reg[j]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_c_reg[j+1]   <= dv_c_reg[j];
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_rx_reg[j+1]  <= tx ? shx - {1'b0, dv_len_reg[j]} : shx;
                dv_ry_reg[j+1]  <= ty ? shy - {1'b0, dv_len_reg[j]} : shy;
                dv_qx_reg[j+1]  <= {dv_qx_reg[j][ccc_pkg::FB-1:0], tx};
                dv_qy_reg[j+1]  <= {dv_qy_reg[j][ccc_pkg::FB-1:0], ty};
            end
        end
    end

    // Stage F: reach, zero normal for coincident centres
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_c_reg     <= dv_c_reg[ccc_pkg::FB];
            f_reach_reg <= $signed({2'b00, dv_c_reg[ccc_pkg::FB].r1}) -
                           $signed({2'b00, dv_c_reg[ccc_pkg::FB].depth});
            if (dv_len_reg[ccc_pkg::FB] == '0)
            begin
                f_qx_reg <= '0;
                f_qy_reg <= '0;
            end
            else
            begin
                f_qx_reg <= dv_qx_reg[ccc_pkg::FB];
                f_qy_reg <= dv_qy_reg[ccc_pkg::FB];
            end
        end
    end

    // Stage G: signed normal, reach magnitude
    always_comb
    begin
        g_c_next    = f_c_reg;
        g_c_next.nx = f_c_reg.sx ? -$signed({1'b0, f_qx_reg}) : $signed({1'b0, f_qx_reg});
        g_c_next.ny = f_c_reg.sy ? -$signed({1'b0, f_qy_reg}) : $signed({1'b0, f_qy_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_c_reg    <= g_c_next;
            g_qx_reg   <= f_qx_reg;
            g_qy_reg   <= f_qy_reg;
            g_rneg_reg <= f_reach_reg[ccc_pkg::CW];
            g_rm_reg   <= f_reach_reg[ccc_pkg::CW] ? ccc_pkg::CW'(-f_reach_reg)
                                                   : ccc_pkg::CW'(f_reach_reg);
        end
    end

    // Stage H: offset products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_c_reg    <= g_c_reg;
            h_px_reg   <= ccc_pkg::PW'(g_qx_reg) * ccc_pkg::PW'(g_rm_reg);
            h_py_reg   <= ccc_pkg::PW'(g_qy_reg) * ccc_pkg::PW'(g_rm_reg);
            h_negx_reg <= g_c_reg.sx ^ g_rneg_reg;
            h_negy_reg <= g_c_reg.sy ^ g_rneg_reg;
        end
    end

    // Stage I: truncate toward zero and apply sign
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_c_reg  <= h_c_reg;
            i_ox_reg <= h_negx_reg ? -$signed({1'b0, h_px_reg[ccc_pkg::PW-1:ccc_pkg::FB]})
                                   :  $signed({1'b0, h_px_reg[ccc_pkg::PW-1:ccc_pkg::FB]});
            i_oy_reg <= h_negy_reg ? -$signed({1'b0, h_py_reg[ccc_pkg::PW-1:ccc_pkg::FB]})
                                   :  $signed({1'b0, h_py_reg[ccc_pkg::PW-1:ccc_pkg::FB]});
        end
    end

    // Stage J: contact point with saturation, output register
    assign vx_next = (ccc_pkg::CW+3)'(i_c_reg.x1) - (ccc_pkg::CW+3)'(i_ox_reg);
    assign vy_next = (ccc_pkg::CW+3)'(i_c_reg.y1) - (ccc_pkg::CW+3)'(i_oy_reg);

    function automatic logic signed [ccc_pkg::CW-1:0] sat
    (
        input logic signed [ccc_pkg::CW+2:0] v
    );
        logic fits;
        fits = (v[ccc_pkg::CW+2:ccc_pkg::CW-1] == '0) ||
               (v[ccc_pkg::CW+2:ccc_pkg::CW-1] == '1);
        if (fits)
            return v[ccc_pkg::CW-1:0];
        else if (v[ccc_pkg::CW+2])
            return {1'b1, {(ccc_pkg::CW-1){1'b0}}};
        else
            return {1'b0, {(ccc_pkg::CW-1){1'b1}}};
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_coll_reg <= i_c_reg.coll;
            if (i_c_reg.coll)
            begin
                out_nx_reg    <= i_c_reg.nx;
                out_ny_reg    <= i_c_reg.ny;
                out_cx_reg    <= sat(vx_next);
                out_cy_reg    <= sat(vy_next);
                out_depth_reg <= i_c_reg.depth;
            end
            else
            begin
                out_nx_reg    <= '0;
                out_ny_reg    <= '0;
                out_cx_reg    <= '0;
                out_cy_reg    <= '0;
                out_depth_reg <= '0;
            end
        end
    end

    assign contact_out.valid     = out_v_reg;
    assign contact_out.colliding = out_coll_reg;
    assign contact_out.normal_x  = out_nx_reg;
    assign contact_out.normal_y  = out_ny_reg;
    assign contact_out.contact_x = out_cx_reg;
    assign contact_out.contact_y = out_cy_reg;
    assign contact_out.depth     = out_depth_reg;

`ifndef NO_ASSERTIONS
    // Separated circles report all-zero fields
    a_apart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_coll_reg) |->
        (out_nx_reg == '0 && out_ny_reg == '0 && out_depth_reg == '0 &&
         out_cx_reg == '0 && out_cy_reg == '0))
        else $error("nonzero fields on separated result");

    // Normal components never exceed one
    a_normal_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |->
        (out_nx_reg <= $signed(ccc_pkg::NW'(1 << ccc_pkg::FB)) &&
         out_nx_reg >= -$signed(ccc_pkg::NW'(1 << ccc_pkg::FB)) &&
         out_ny_reg <= $signed(ccc_pkg::NW'(1 << ccc_pkg::FB)) &&
         out_ny_reg >= -$signed(ccc_pkg::NW'(1 << ccc_pkg::FB))))
        else $error("normal out of range");

    // Square root result is the floor root of the squared distance
    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_v_reg[ccc_pkg::RW] && sq_c_reg[ccc_pkg::RW].coll) |->
        ((ccc_pkg::D2W'(len) * ccc_pkg::D2W'(len) <=
          ccc_pkg::D2W'(sq_rad_reg[ccc_pkg::RW])) &&
         ((ccc_pkg::D2W'(len) + 1) * (ccc_pkg::D2W'(len) + 1) >
          ccc_pkg::D2W'(sq_rad_reg[ccc_pkg::RW]))))
        else $error("square root stage mismatch");
`endif

endmodule
